// ----- rtl/tfsp_pkg.sv -----
// Package for the telemetry frame sync parser: frame geometry, shared types and
// the sync-byte unpacking function. No dependencies.
`default_nettype none
package tfsp_pkg;

  localparam int SYNC_BYTES      = 4;
  localparam int BODY_DATA_BYTES = 7;
  localparam int BODY_LEN        = BODY_DATA_BYTES + 1;
  localparam int FRAME_LEN       = SYNC_BYTES + BODY_LEN;
  localparam int CNT_W           = $clog2(FRAME_LEN + 1);
  localparam int SYNC_IDX_W      = $clog2(SYNC_BYTES);
  localparam int SYNC_REG_W      = 32;
  localparam int RSV_REG_W       = 8;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 1'd1;

  typedef logic [SYNC_BYTES-1:0][7:0] sync_bytes_t;
  typedef logic [BODY_LEN-1:0][7:0]   body_t;
  typedef logic [SYNC_BYTES-1:0]      match_t;

  typedef struct packed {
    logic             csum_ok;
    logic [CNT_W-1:0] resync_cnt;
  } row_status_t;

  function automatic sync_bytes_t sync_bytes(input logic [SYNC_REG_W-1:0] word);
    sync_bytes_t s;
    int          sh;
    for (int i = 0; i < SYNC_BYTES; i++) begin
      sh = 8 * (SYNC_BYTES - 1 - i);
      if (sh < SYNC_REG_W) begin
        s[i] = word[sh +: 8];
      end else begin
        s[i] = '0;
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tfsp_if.sv -----
// Handshake channels of the telemetry frame sync parser: received bytes in,
// decoded frame results out. Depends on nothing.
`default_nettype none
interface tfsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tfsp_result_if;
  logic        valid;
  logic        ready;
  logic        frame_good;
  logic        data_valid;
  logic [4:0]  subsystem_id;
  logic [4:0]  component_id;
  logic [31:0] temperature_bits;

  modport source (output valid, output frame_good, output data_valid,
                  output subsystem_id, output component_id,
                  output temperature_bits, input ready);
  modport sink (input valid, input frame_good, input data_valid,
                input subsystem_id, input component_id,
                input temperature_bits, output ready);
endinterface
`default_nettype wire

// ----- rtl/tfsp_cell.sv -----
// One body byte cell: holds a byte, takes its neighbor's byte on shift and
// compares its byte against every sync byte. Depends on tfsp_pkg.
`default_nettype none
module tfsp_cell (
  input  wire logic                  clk_i,
  input  wire logic                  shift_i,
  input  wire logic [7:0]            data_i,
  input  wire tfsp_pkg::sync_bytes_t sync_i,
  output logic [7:0]                 data_o,
  output tfsp_pkg::match_t           match_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < tfsp_pkg::SYNC_BYTES; k++) begin
      match_o[k] = (data_q == sync_i[k]);
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- rtl/tfsp_row.sv -----
// Row of body cells with checksum and resync search over the cell matches.
// Depends on tfsp_pkg and tfsp_cell.
`default_nettype none
module tfsp_row (
  input  wire logic                  clk_i,
  input  wire logic                  shift_i,
  input  wire logic [7:0]            byte_i,
  input  wire tfsp_pkg::sync_bytes_t sync_i,
  output tfsp_pkg::body_t            body_o,
  output tfsp_pkg::row_status_t      status_o
);

  logic [tfsp_pkg::BODY_LEN-1:0][7:0]   chain_in;
  tfsp_pkg::match_t [tfsp_pkg::BODY_LEN-1:0] match;
  logic [tfsp_pkg::BODY_LEN-tfsp_pkg::SYNC_BYTES:0] win_hit;
  logic [tfsp_pkg::SYNC_BYTES-1:0]      suf_hit;
  logic [7:0]                           csum;

  for (genvar g = 0; g < tfsp_pkg::BODY_LEN; g++) begin : g_cell
    if (g == tfsp_pkg::BODY_LEN - 1) begin : g_tail
      assign chain_in[g] = byte_i;
    end else begin : g_link
      assign chain_in[g] = body_o[g+1];
    end
    tfsp_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .data_i  (chain_in[g]),
      .sync_i  (sync_i),
      .data_o  (body_o[g]),
      .match_o (match[g])
    );
  end

  always_comb begin
    for (int p = 0; p <= tfsp_pkg::BODY_LEN - tfsp_pkg::SYNC_BYTES; p++) begin
      win_hit[p] = 1'b1;
      for (int k = 0; k < tfsp_pkg::SYNC_BYTES; k++) begin
        win_hit[p] = win_hit[p] & match[p+k][k];
      end
    end
    suf_hit[0] = 1'b0;
    for (int i = 1; i < tfsp_pkg::SYNC_BYTES; i++) begin
      suf_hit[i] = 1'b1;
      for (int k = 0; k < i; k++) begin
        suf_hit[i] = suf_hit[i] & match[tfsp_pkg::BODY_LEN-i+k][k];
      end
    end
  end

  always_comb begin
    csum = '0;
    for (int k = 0; k < tfsp_pkg::BODY_DATA_BYTES; k++) begin
      csum = csum ^ body_o[k];
    end
    status_o.csum_ok = (csum == body_o[tfsp_pkg::BODY_LEN-1]);
    status_o.resync_cnt = '0;
    for (int i = 1; i < tfsp_pkg::SYNC_BYTES; i++) begin
      if (suf_hit[i]) begin
        status_o.resync_cnt = tfsp_pkg::CNT_W'(i);
      end
    end
    for (int p = tfsp_pkg::BODY_LEN - tfsp_pkg::SYNC_BYTES; p >= 0; p--) begin
      if (win_hit[p]) begin
        status_o.resync_cnt = tfsp_pkg::CNT_W'(tfsp_pkg::BODY_LEN - p);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/telemetry_frame_sync_parser.sv -----
// Top level of the telemetry frame sync parser: sync search, frame control,
// header decode and output register. Depends on tfsp_pkg, tfsp_if, tfsp_row.
//
//   channel   direction  handshake            payload
//   in_byte   sink       valid/ready          rx_byte
//   out_res   source     valid/ready          frame_good, data_valid, subsystem_id,
//                                             component_id, temperature_bits
//   cfg       write      cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// Each byte has an accept step, which matches a sync byte or shifts the byte into
// the cell row, and then an evaluation step, which evaluates checksum and resync
// over the row and loads the output register; a stalled output holds it back.
// Reset clears count, control and configuration; body cells hold no reset.
`default_nettype none
module telemetry_frame_sync_parser (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tfsp_byte_if.sink                           in_byte,
  tfsp_result_if.source                       out_res,
  input  wire logic                           cfg_we_i,
  input  wire logic [tfsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tfsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [2:0] VER_A  = 3'd1;
  localparam logic [2:0] VER_B  = 3'd2;
  localparam logic [2:0] TYPE_OK = 3'd1;
  localparam logic [4:0] SUB_A  = 5'd1;
  localparam logic [4:0] SUB_B  = 5'd3;
  localparam logic [4:0] SUB_C  = 5'd5;

  logic [tfsp_pkg::SYNC_REG_W-1:0] sync_word_q;
  logic [tfsp_pkg::RSV_REG_W-1:0]  reserved_q;
  logic [tfsp_pkg::CNT_W-1:0]      fc_q, fc_d;
  logic                            busy_q, busy_d;
  logic                            out_valid_q, out_valid_d;
  logic                            good_q, good_d;
  logic                            dvalid_q, dvalid_d;
  logic [4:0]                      sub_q, sub_d;
  logic [4:0]                      comp_q, comp_d;
  logic [31:0]                     temp_q, temp_d;
  logic                            in_acc;
  logic                            shift;
  tfsp_pkg::sync_bytes_t           sync_b;
  tfsp_pkg::body_t                 body;
  tfsp_pkg::row_status_t           status;

  function automatic logic comp_ok(input logic [4:0] sub, input logic [4:0] comp);
    logic ok;
    unique case (sub)
      SUB_A:   ok = (comp == 5'd20) || (comp == 5'd21) || (comp == 5'd22) ||
                    (comp == 5'd23) || (comp == 5'd30) || (comp == 5'd31);
      SUB_B:   ok = (comp == 5'd0);
      SUB_C:   ok = (comp == 5'd1) || (comp == 5'd2) || (comp == 5'd10) ||
                    (comp == 5'd20);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign sync_b         = tfsp_pkg::sync_bytes(sync_word_q);
  assign in_byte.ready  = !busy_q;
  assign in_acc         = in_byte.valid && !busy_q;

  tfsp_row u_row (
    .clk_i    (clk_i),
    .shift_i  (shift),
    .byte_i   (in_byte.rx_byte),
    .sync_i   (sync_b),
    .body_o   (body),
    .status_o (status)
  );

  always_comb begin
    fc_d        = fc_q;
    busy_d      = busy_q;
    shift       = 1'b0;
    out_valid_d = out_valid_q && !out_res.ready;
    good_d      = good_q;
    dvalid_d    = dvalid_q;
    sub_d       = sub_q;
    comp_d      = comp_q;
    temp_d      = temp_q;
    if (in_acc) begin
      busy_d = 1'b1;
      if (fc_q < tfsp_pkg::CNT_W'(tfsp_pkg::SYNC_BYTES)) begin
        if (in_byte.rx_byte == sync_b[fc_q[tfsp_pkg::SYNC_IDX_W-1:0]]) begin
          fc_d = fc_q + tfsp_pkg::CNT_W'(1);
        end else begin
          fc_d = '0;
        end
      end else if (fc_q >= tfsp_pkg::CNT_W'(tfsp_pkg::FRAME_LEN)) begin
        fc_d = '0;
      end else begin
        shift = 1'b1;
        fc_d  = fc_q + tfsp_pkg::CNT_W'(1);
      end
    end else if (busy_q && (!out_valid_q || out_res.ready)) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      good_d      = 1'b0;
      dvalid_d    = 1'b0;
      sub_d       = '0;
      comp_d      = '0;
      temp_d      = '0;
      if (fc_q == tfsp_pkg::CNT_W'(tfsp_pkg::FRAME_LEN)) begin
        if (status.csum_ok) begin
          fc_d     = '0;
          good_d   = 1'b1;
          sub_d    = body[0][4:0];
          comp_d   = body[1][7:3];
          temp_d   = {body[3], body[4], body[5], body[6]};
          dvalid_d = ((body[0][7:5] == VER_A) || (body[0][7:5] == VER_B)) &&
                     comp_ok(body[0][4:0], body[1][7:3]) &&
                     (body[2] == reserved_q) && (body[1][2:0] == TYPE_OK);
        end else begin
          fc_d = status.resync_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= '0;
      reserved_q  <= '0;
      fc_q        <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tfsp_pkg::CFG_SYNC_WORD: sync_word_q <= cfg_wdata_i[tfsp_pkg::SYNC_REG_W-1:0];
          tfsp_pkg::CFG_RESERVED:  reserved_q  <= cfg_wdata_i[tfsp_pkg::RSV_REG_W-1:0];
          default: ;
        endcase
      end
      fc_q        <= fc_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    good_q   <= good_d;
    dvalid_q <= dvalid_d;
    sub_q    <= sub_d;
    comp_q   <= comp_d;
    temp_q   <= temp_d;
  end

  assign out_res.valid            = out_valid_q;
  assign out_res.frame_good       = good_q;
  assign out_res.data_valid       = dvalid_q;
  assign out_res.subsystem_id     = sub_q;
  assign out_res.component_id     = comp_q;
  assign out_res.temperature_bits = temp_q;

`ifndef SYNTHESIS
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_byte.valid && in_byte.ready |=> !in_byte.ready)
    else $error("input accepted while previous transaction still in evaluation");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= tfsp_pkg::CNT_W'(tfsp_pkg::FRAME_LEN))
    else $error("frame count beyond frame length");
  a_full_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q == tfsp_pkg::CNT_W'(tfsp_pkg::FRAME_LEN) |-> busy_q)
    else $error("full frame held without pending evaluation");
  a_valid_needs_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && out_res.data_valid |-> out_res.frame_good)
    else $error("data_valid without frame_good");
`endif

endmodule
`default_nettype wire

// ----- test/telemetry_frame_sync_parser_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the telemetry frame sync parser: tracks sync search, body capture,
// checksum resync and header decode, and compares every result transaction in order.
// Depends on tfsp_pkg and the tfsp_if channel interfaces.
module telemetry_frame_sync_parser_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tfsp_byte_if                                byte_mon,
  tfsp_result_if                              res_mon,
  input  wire logic                           cfg_we_i,
  input  wire logic [tfsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tfsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                         mismatch_count,
  output int unsigned                         pending_results
);
  import tfsp_pkg::*;

  localparam logic [4:0] SUBSYS_A      = 5'd1;
  localparam logic [4:0] SUBSYS_B      = 5'd3;
  localparam logic [4:0] SUBSYS_C      = 5'd5;
  localparam logic [2:0] VER_LOW       = 3'd1;
  localparam logic [2:0] VER_HIGH      = 3'd2;
  localparam logic [2:0] FRAME_TYPE_OK = 3'd1;

  typedef struct packed {
    logic        frame_good;
    logic        data_valid;
    logic [4:0]  subsystem_id;
    logic [4:0]  component_id;
    logic [31:0] temperature_bits;
  } frame_result_t;

  logic [SYNC_REG_W-1:0] sync_word_q;
  logic [RSV_REG_W-1:0]  reserved_q;
  int unsigned           held_bytes;
  logic [7:0]            body_q [BODY_LEN];
  frame_result_t         expected_frames [$];

  function automatic logic [7:0] sync_byte_at(input int idx);
    int sh;
    sh = 8 * (SYNC_BYTES - 1 - idx);
    if (sh >= SYNC_REG_W) begin
      return 8'h00;
    end
    return sync_word_q[sh +: 8];
  endfunction

  function automatic bit sync_matches(input int pos, input int len);
    for (int k = 0; k < len; k++) begin
      if (body_q[pos + k] != sync_byte_at(k)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit component_allowed(input logic [4:0] sub, input logic [4:0] comp);
    case (sub)
      SUBSYS_A: return comp inside {5'd20, 5'd21, 5'd22, 5'd23, 5'd30, 5'd31};
      SUBSYS_B: return comp == 5'd0;
      SUBSYS_C: return comp inside {5'd1, 5'd2, 5'd10, 5'd20};
      default:  return 1'b0;
    endcase
  endfunction

  task automatic resync_body();
    int moved;
    for (int p = 0; p + SYNC_BYTES <= BODY_LEN; p++) begin
      if (sync_matches(p, SYNC_BYTES)) begin
        moved = BODY_LEN - p - SYNC_BYTES;
        for (int k = 0; k < moved; k++) begin
          body_q[k] = body_q[p + SYNC_BYTES + k];
        end
        held_bytes = SYNC_BYTES + moved;
        return;
      end
    end
    held_bytes = 0;
    for (int i = SYNC_BYTES - 1; i >= 1; i--) begin
      if (sync_matches(BODY_LEN - i, i)) begin
        held_bytes = i;
        return;
      end
    end
  endtask

  task automatic framer_step(input logic [7:0] rx, output frame_result_t res);
    logic [7:0] sum;
    logic [2:0] ver;
    logic [2:0] frame_type;
    logic [4:0] sub;
    logic [4:0] comp;
    res = '0;
    if (held_bytes < SYNC_BYTES) begin
      if (rx == sync_byte_at(held_bytes)) begin
        held_bytes++;
      end else begin
        held_bytes = 0;
      end
      return;
    end
    if (held_bytes >= FRAME_LEN) begin
      held_bytes = 0;
      return;
    end
    body_q[held_bytes - SYNC_BYTES] = rx;
    held_bytes++;
    if (held_bytes != FRAME_LEN) begin
      return;
    end
    sum = 8'h00;
    for (int k = 0; k < BODY_DATA_BYTES; k++) begin
      sum ^= body_q[k];
    end
    if (sum != body_q[BODY_LEN-1]) begin
      resync_body();
      return;
    end
    held_bytes = 0;
    ver        = body_q[0][7:5];
    sub        = body_q[0][4:0];
    comp       = body_q[1][7:3];
    frame_type = body_q[1][2:0];
    res.frame_good       = 1'b1;
    res.data_valid       = (ver == VER_LOW || ver == VER_HIGH) && component_allowed(sub, comp)
                           && body_q[2] == reserved_q && frame_type == FRAME_TYPE_OK;
    res.subsystem_id     = sub;
    res.component_id     = comp;
    res.temperature_bits = {body_q[3], body_q[4], body_q[5], body_q[6]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got_res;
    frame_result_t want_res;
    frame_result_t new_res;
    if (!rst_ni) begin
      held_bytes  = 0;
      sync_word_q = '0;
      reserved_q  = '0;
      expected_frames.delete();
      mismatch_count  <= 0;
      pending_results <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_WORD: sync_word_q = cfg_wdata_i[SYNC_REG_W-1:0];
          CFG_RESERVED:  reserved_q  = cfg_wdata_i[RSV_REG_W-1:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        got_res.frame_good       = res_mon.frame_good;
        got_res.data_valid       = res_mon.data_valid;
        got_res.subsystem_id     = res_mon.subsystem_id;
        got_res.component_id     = res_mon.component_id;
        got_res.temperature_bits = res_mon.temperature_bits;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual good=%0b valid=%0b",
                   $time, got_res.frame_good, got_res.data_valid);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want_res = expected_frames.pop_front();
          if (got_res !== want_res) begin
            $display("%0t: expected good=%0b valid=%0b subsys=%0d comp=%0d temp=%08h",
                     $time, want_res.frame_good, want_res.data_valid,
                     want_res.subsystem_id, want_res.component_id,
                     want_res.temperature_bits);
            $display("%0t:   actual good=%0b valid=%0b subsys=%0d comp=%0d temp=%08h",
                     $time, got_res.frame_good, got_res.data_valid,
                     got_res.subsystem_id, got_res.component_id,
                     got_res.temperature_bits);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        framer_step(byte_mon.rx_byte, new_res);
        expected_frames.push_back(new_res);
      end
      pending_results <= expected_frames.size();
    end
  end

endmodule

// ----- test/telemetry_frame_sync_parser_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for telemetry_frame_sync_parser: drives framed, corrupted and noisy
// byte streams under several sync words with random gaps and result stalls.
// Depends on tfsp_pkg, tfsp_if, telemetry_frame_sync_parser and telemetry_frame_sync_parser_checker.
module telemetry_frame_sync_parser_tb;
  import tfsp_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned ITEM_TARGET  = 500;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam logic [4:0] SUBSYS_A      = 5'd1;
  localparam logic [4:0] SUBSYS_B      = 5'd3;
  localparam logic [4:0] SUBSYS_C      = 5'd5;
  localparam logic [2:0] FRAME_TYPE_OK = 3'd1;
  localparam logic [4:0] SUBSYS_A_COMPS [6] = '{5'd20, 5'd21, 5'd22, 5'd23, 5'd30, 5'd31};
  localparam logic [4:0] SUBSYS_C_COMPS [4] = '{5'd1, 5'd2, 5'd10, 5'd20};

  typedef enum int {
    FR_CLEAN,
    FR_MIXED,
    FR_BAD_SUM,
    FR_SYNC_BODY,
    FR_SYNC_TAIL,
    FR_BROKEN,
    FR_NOISE
  } frame_kind_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatch_count;
  int unsigned           pending_results;
  int unsigned           idle_cycles;
  int unsigned           items_sent;
  bit                    burst;
  logic [SYNC_REG_W-1:0] cur_sync;
  logic [RSV_REG_W-1:0]  cur_rsv;
  logic [7:0]            frame_body [BODY_LEN];
  logic [7:0]            lead_body [BODY_LEN];

  tfsp_byte_if   rx_if ();
  tfsp_result_if res_if ();

  telemetry_frame_sync_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte     (rx_if),
    .out_res     (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  telemetry_frame_sync_parser_checker frame_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_mon        (rx_if),
    .res_mon         (res_if),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_kind_e pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return FR_CLEAN;
    if (roll < 55) return FR_MIXED;
    if (roll < 65) return FR_BAD_SUM;
    if (roll < 75) return FR_SYNC_BODY;
    if (roll < 85) return FR_SYNC_TAIL;
    if (roll < 93) return FR_BROKEN;
    return FR_NOISE;
  endfunction

  function automatic logic [7:0] sync_byte_of(input int idx);
    return cur_sync[8 * (SYNC_BYTES - 1 - idx) +: 8];
  endfunction

  function automatic logic [7:0] body_xor(input logic [7:0] bytes [BODY_LEN]);
    logic [7:0] sum;
    sum = 8'h00;
    for (int k = 0; k < BODY_DATA_BYTES; k++) begin
      sum ^= bytes[k];
    end
    return sum;
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= value;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_sync(input int from, input int upto);
    for (int k = from; k < upto; k++) begin
      send_byte(sync_byte_of(k));
    end
  endtask

  task automatic send_body(input logic [7:0] bytes [BODY_LEN], input int from);
    for (int k = from; k < BODY_LEN; k++) begin
      send_byte(bytes[k]);
    end
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [SYNC_REG_W-1:0] sync, input logic [RSV_REG_W-1:0] rsv);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SYNC_WORD;
    cfg_wdata <= CFG_DATA_W'(sync);
    @(posedge clk_i);
    cfg_idx   <= CFG_RESERVED;
    cfg_wdata <= CFG_DATA_W'(rsv);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_sync = sync;
    cur_rsv  = rsv;
  endtask

  task automatic fill_clean_frame();
    logic [4:0] sub;
    logic [4:0] comp;
    case ($urandom_range(0, 2))
      0: begin
        sub  = SUBSYS_A;
        comp = SUBSYS_A_COMPS[$urandom_range(0, 5)];
      end
      1: begin
        sub  = SUBSYS_B;
        comp = 5'd0;
      end
      default: begin
        sub  = SUBSYS_C;
        comp = SUBSYS_C_COMPS[$urandom_range(0, 3)];
      end
    endcase
    frame_body[0] = {3'($urandom_range(1, 2)), sub};
    frame_body[1] = {comp, FRAME_TYPE_OK};
    frame_body[2] = cur_rsv;
    for (int k = 3; k < BODY_DATA_BYTES; k++) begin
      frame_body[k] = 8'($urandom);
    end
    frame_body[BODY_LEN-1] = body_xor(frame_body);
  endtask

  task automatic mess_fields();
    if ($urandom_range(0, 3) == 0) frame_body[0][7:5] = 3'($urandom);
    if ($urandom_range(0, 3) == 0) frame_body[0][4:0] = 5'($urandom);
    if ($urandom_range(0, 3) == 0) frame_body[1][7:3] = 5'($urandom);
    if ($urandom_range(0, 3) == 0) frame_body[1][2:0] = 3'($urandom);
    if ($urandom_range(0, 3) == 0) frame_body[2] = 8'($urandom);
    frame_body[BODY_LEN-1] = body_xor(frame_body);
  endtask

  task automatic run_frame(input frame_kind_e kind, input int place);
    int pos;
    int moved;
    case (kind)
      FR_CLEAN, FR_MIXED: begin
        fill_clean_frame();
        if (kind == FR_MIXED) mess_fields();
        send_sync(0, SYNC_BYTES);
        send_body(frame_body, 0);
      end
      FR_BAD_SUM: begin
        fill_clean_frame();
        if ($urandom_range(0, 1) == 0) mess_fields();
        frame_body[BODY_LEN-1] ^= 8'($urandom_range(1, 255));
        send_sync(0, SYNC_BYTES);
        send_body(frame_body, 0);
      end
      FR_SYNC_BODY: begin
        // embed a sync word in a body forced to fail if pos > 0; bytes after it open a clean frame
        fill_clean_frame();
        pos   = (place < 0) ? $urandom_range(0, BODY_LEN - SYNC_BYTES) : place;
        moved = BODY_LEN - pos - SYNC_BYTES;
        for (int k = 0; k < BODY_LEN; k++) lead_body[k] = 8'($urandom);
        for (int k = 0; k < SYNC_BYTES; k++) lead_body[pos + k] = sync_byte_of(k);
        for (int k = 0; k < moved; k++) lead_body[pos + SYNC_BYTES + k] = frame_body[k];
        if (pos > 0 && body_xor(lead_body) == lead_body[BODY_LEN-1]) lead_body[0] ^= 8'h01;
        send_sync(0, SYNC_BYTES);
        send_body(lead_body, 0);
        send_body(frame_body, moved);
      end
      FR_SYNC_TAIL: begin
        // end a failing body in a sync prefix, then finish that sync word
        pos = (place < 0) ? $urandom_range(1, SYNC_BYTES - 1) : place;
        fill_clean_frame();
        for (int k = 0; k < pos; k++) frame_body[BODY_LEN - pos + k] = sync_byte_of(k);
        if (body_xor(frame_body) == frame_body[BODY_LEN-1]) frame_body[0] ^= 8'h01;
        send_sync(0, SYNC_BYTES);
        send_body(frame_body, 0);
        send_sync(pos, SYNC_BYTES);
        fill_clean_frame();
        send_body(frame_body, 0);
      end
      FR_BROKEN: begin
        pos = $urandom_range(1, SYNC_BYTES - 1);
        send_sync(0, pos);
        send_byte(sync_byte_of(pos) ^ 8'($urandom_range(1, 255)));
      end
      default: begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    endcase
  endtask

  initial begin
    res_if.ready <= 1'b0;
  end

  initial begin
    int unsigned hold_left;
    bit          open_now;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0) begin
        open_now     = ($urandom_range(0, 3) != 0);
        hold_left    = open_now ? $urandom_range(1, 40) : pick_gap() + 1;
        res_if.ready <= open_now;
      end else begin
        hold_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned phase_end;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_SYNC_WORD;
    cfg_wdata     <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    idle_cycles   = 0;
    items_sent    = 0;
    burst         = 1'b0;
    cur_sync      = '0;
    cur_rsv       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(32'h1ACF_FC1D, 8'h00);
    // repeated first sync byte: the mismatch is not retried as a new start
    send_byte(sync_byte_of(0));
    send_byte(sync_byte_of(0));
    send_sync(1, SYNC_BYTES);
    run_frame(FR_SYNC_BODY, 0);
    send_byte(8'h00);
    send_byte(8'hFF);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_config(32'hFFFF_FFFF, 8'hFF);
        1:       set_config(32'h0000_0000, 8'h00);
        2:       set_config(32'hAAAA_AAAA, 8'($urandom));
        3:       set_config($urandom, 8'($urandom));
        default: set_config(32'h1ACF_FC1D, 8'hFF);
      endcase
      phase_end = items_sent + ITEM_TARGET / NUM_PHASES;
      while (items_sent < phase_end) begin
        burst = ($urandom_range(0, 5) == 0);
        run_frame(pick_kind(), -1);
      end
    end

    burst = 1'b0;
    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- telemetry_frame_sync_parser.f -----
rtl/tfsp_pkg.sv
rtl/tfsp_if.sv
rtl/tfsp_cell.sv
rtl/tfsp_row.sv
rtl/telemetry_frame_sync_parser.sv
test/telemetry_frame_sync_parser_checker.sv
test/telemetry_frame_sync_parser_tb.sv
